>>> rtl/core/rlm_pkg.sv
// Shared types, field widths and codes for the ready-list matchmaker.
`default_nettype none

package rlm_pkg;

    localparam int FUNC_W      = 3;
    localparam int ID_W        = 31;
    localparam int RATING_W    = 16;
    localparam int MAXC_W      = 5;
    localparam int STATUS_W    = 4;
    localparam int LCNT_W      = 5;
    localparam int MAX_RESULTS = 16;
    localparam int ENTRY_W     = ID_W + RATING_W;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_FIELD_W = 2 * ID_W + LCNT_W;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_IDX_TOLERANCE = 1'b0;
    localparam logic [RATING_W-1:0] TOLERANCE_RESET = 16'd100;

    localparam logic [FUNC_W-1:0] FN_SET_READY = 3'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RANDOM    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RATED     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LIST_IDS  = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 4'd0,
        ST_UPDATED = 4'd1,
        ST_FULL    = 4'd2,
        ST_REMOVED = 4'd3,
        ST_ABSENT  = 4'd4,
        ST_MATCHED = 4'd5,
        ST_NOMATCH = 4'd6,
        ST_ENTRY   = 4'd7,
        ST_EMPTY   = 4'd8
    } status_t;

    typedef struct packed {
        logic    load;
        logic    scan_eval;
        logic    wr_set;
        logic    cnt_inc;
        logic    cmp_init;
        logic    ptr_skip;
        logic    cmp_write;
        logic    cnt_sub;
        logic    set_status;
        status_t status;
        logic    out_result;
        logic    out_entry;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] in_func;
        logic [FUNC_W-1:0] req_func;
        logic              cnt_zero;
        logic              list_none;
        logic              scan_last;
        logic              self_found;
        logic              opp_found;
        logic              full;
        logic              cmp_done;
        logic              cmp_skip;
        logic              out_free;
        logic              list_last;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/rlm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rlm_ram #(
    parameter int WIDTH = 47,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/rlm_ctrl.sv
// Sequencer that steps the datapath through scan, update, compaction and output.
`default_nettype none

module rlm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output rlm_pkg::cmd_t      cmd,
    input  wire rlm_pkg::sts_t sts
);

    import rlm_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN_RD = 9'b000000010,
        S_SCAN_EV = 9'b000000100,
        S_DECIDE  = 9'b000001000,
        S_CMP_CHK = 9'b000010000,
        S_CMP_WR  = 9'b000100000,
        S_RESULT  = 9'b001000000,
        S_LIST_RD = 9'b010000000,
        S_LIST_EV = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.status = ST_ADDED;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    priority if (sts.in_func > FN_LIST_IDS)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (sts.in_func == FN_LIST_IDS)
                    begin
                        if (sts.list_none)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ST_EMPTY;
                            state_next     = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_LIST_RD;
                        end
                    end
                    else if (sts.cnt_zero)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
                state_next    = sts.scan_last ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE:
            begin
                cmd.set_status = 1'b1;
                state_next     = S_RESULT;
                unique case (sts.req_func)
                    FN_SET_READY:
                    begin
                        if (sts.self_found)
                        begin
                            cmd.wr_set = 1'b1;
                            cmd.status = ST_UPDATED;
                        end
                        else if (!sts.full)
                        begin
                            cmd.wr_set  = 1'b1;
                            cmd.cnt_inc = 1'b1;
                            cmd.status  = ST_ADDED;
                        end
                        else
                        begin
                            cmd.status = ST_FULL;
                        end
                    end
                    FN_REMOVE:
                    begin
                        if (sts.self_found)
                        begin
                            cmd.cmp_init = 1'b1;
                            cmd.status   = ST_REMOVED;
                            state_next   = S_CMP_CHK;
                        end
                        else
                        begin
                            cmd.status = ST_ABSENT;
                        end
                    end
                    FN_RANDOM, FN_RATED:
                    begin
                        if (sts.opp_found)
                        begin
                            cmd.cmp_init = 1'b1;
                            cmd.status   = ST_MATCHED;
                            state_next   = S_CMP_CHK;
                        end
                        else
                        begin
                            cmd.status = ST_NOMATCH;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b0;
                        state_next     = S_IDLE;
                    end
                endcase
            end
            S_CMP_CHK:
            begin
                priority if (sts.cmp_done)
                begin
                    cmd.cnt_sub = 1'b1;
                    state_next  = S_RESULT;
                end
                else if (sts.cmp_skip)
                begin
                    cmd.ptr_skip = 1'b1;
                end
                else
                begin
                    state_next = S_CMP_WR;
                end
            end
            S_CMP_WR:
            begin
                cmd.cmp_write = 1'b1;
                state_next    = S_CMP_CHK;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_result = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_LIST_RD:
            begin
                state_next = S_LIST_EV;
            end
            S_LIST_EV:
            begin
                if (sts.out_free)
                begin
                    cmd.out_entry = 1'b1;
                    state_next    = sts.list_last ? S_IDLE : S_LIST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A request is only taken on a completed input beat.
    a_load_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (s_tvalid && s_tready))
        else $error("request loaded without an input beat");

    // Compaction always hands over to the result stage, which queues the result beat.
    a_cmp_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_sub |=> (state_reg == S_RESULT))
        else $error("compaction did not hand over to the result stage");

endmodule

`default_nettype wire

>>> rtl/core/rlm_dp.sv
// Datapath: list storage, request registers, scan and compaction pointers, output register.
`default_nettype none

module rlm_dp #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [rlm_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  wire logic [rlm_pkg::FUNC_W-1:0]           s_tuser,
    input  wire logic [rlm_pkg::RATING_W-1:0]         rating_tolerance,
    input  wire rlm_pkg::cmd_t                        cmd,
    output rlm_pkg::sts_t                             sts,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [rlm_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic      [rlm_pkg::STATUS_W-1:0]         m_tuser,
    output logic                                      m_tlast
);

    import rlm_pkg::*;

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

    // Input beat fields.
    logic [ID_W-1:0]     in_id;
    logic [RATING_W-1:0] in_rating;
    logic [MAXC_W-1:0]   in_maxc;

    assign in_id     = s_tdata[ID_W-1:0];
    assign in_rating = s_tdata[ID_W +: RATING_W];
    assign in_maxc   = s_tdata[ID_W + RATING_W +: MAXC_W];

    logic [FUNC_W-1:0]   req_func_reg,    req_func_next;
    logic [ID_W-1:0]     req_id_reg,      req_id_next;
    logic [RATING_W-1:0] req_rating_reg,  req_rating_next;
    logic [MAXC_W-1:0]   list_n_reg,      list_n_next;
    logic [CNT_W-1:0]    count_reg,       count_next;
    logic [CNT_W-1:0]    ptr_reg,         ptr_next;
    logic [IDX_W-1:0]    wptr_reg,        wptr_next;
    logic                self_found_reg,  self_found_next;
    logic [IDX_W-1:0]    self_idx_reg,    self_idx_next;
    logic                opp_found_reg,   opp_found_next;
    logic [IDX_W-1:0]    opp_idx_reg,     opp_idx_next;
    logic [ID_W-1:0]     opp_id_reg,      opp_id_next;
    logic [RATING_W:0]   best_reg,        best_next;
    status_t             status_reg,      status_next;
    logic                out_valid_reg,   out_valid_next;
    status_t             out_status_reg,  out_status_next;
    logic [ID_W-1:0]     out_opp_reg,     out_opp_next;
    logic [ID_W-1:0]     out_ent_reg,     out_ent_next;
    logic                out_last_reg,    out_last_next;
    logic [LCNT_W-1:0]   out_lcnt_reg,    out_lcnt_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [ID_W-1:0]     ent_id;
    logic [RATING_W-1:0] ent_rating;
    logic [RATING_W-1:0] diff;
    logic                tol_ok;
    logic [CNT_W-1:0]    ptr_inc;
    logic                out_free;
    logic                ptr_removed;
    logic [IDX_W-1:0]    first_rm;
    logic [CNT_W-1:0]    nrem;
    logic [CMP_W-1:0]    lim;
    logic [MAXC_W-1:0]   n_in;

    assign ent_id     = ram_rdata[ID_W-1:0];
    assign ent_rating = ram_rdata[ENTRY_W-1:ID_W];
    assign diff       = (ent_rating >= req_rating_reg) ? (ent_rating - req_rating_reg)
                                                       : (req_rating_reg - ent_rating);
    // Strictly smaller than the best so far, so ties keep the earlier entry.
    assign tol_ok     = (diff <= rating_tolerance) && ({1'b0, diff} < best_reg);
    assign ptr_inc    = ptr_reg + CNT_W'(1);
    assign out_free   = !out_valid_reg || m_tready;

    assign ptr_removed = (self_found_reg && (ptr_reg == CNT_W'(self_idx_reg)))
                      || (opp_found_reg && (ptr_reg == CNT_W'(opp_idx_reg)));

    always_comb
    begin
        priority if (self_found_reg && opp_found_reg)
        begin
            first_rm = (self_idx_reg < opp_idx_reg) ? self_idx_reg : opp_idx_reg;
        end
        else if (self_found_reg)
        begin
            first_rm = self_idx_reg;
        end
        else
        begin
            first_rm = opp_idx_reg;
        end
    end

    assign nrem = CNT_W'(self_found_reg) + CNT_W'(opp_found_reg);

    // Number of ids a list request emits, bounded by count, the id limit and the result limit.
    always_comb
    begin
        lim = (CMP_W'(count_reg) < CMP_W'(in_maxc)) ? CMP_W'(count_reg) : CMP_W'(in_maxc);
        if (lim > CMP_W'(MAX_RESULTS))
        begin
            lim = CMP_W'(MAX_RESULTS);
        end
        n_in = MAXC_W'(lim);
    end

    assign ram_we    = cmd.wr_set || cmd.cmp_write;
    assign ram_wdata = cmd.cmp_write ? ram_rdata : {req_rating_reg, req_id_reg};

    always_comb
    begin
        priority if (cmd.cmp_write)
        begin
            ram_waddr = wptr_reg;
        end
        else if (self_found_reg)
        begin
            ram_waddr = self_idx_reg;
        end
        else
        begin
            ram_waddr = count_reg[IDX_W-1:0];
        end
    end

    rlm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.in_func    = s_tuser;
        sts.req_func   = req_func_reg;
        sts.cnt_zero   = (count_reg == '0);
        sts.list_none  = (n_in == '0);
        sts.scan_last  = (ptr_inc == count_reg);
        sts.self_found = self_found_reg;
        sts.opp_found  = opp_found_reg;
        sts.full       = (count_reg == DEPTH_CNT);
        sts.cmp_done   = (ptr_reg >= count_reg);
        sts.cmp_skip   = ptr_removed;
        sts.out_free   = out_free;
        sts.list_last  = (CMP_W'(ptr_inc) == CMP_W'(list_n_reg));
    end

    always_comb
    begin
        req_func_next   = req_func_reg;
        req_id_next     = req_id_reg;
        req_rating_next = req_rating_reg;
        list_n_next     = list_n_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        wptr_next       = wptr_reg;
        self_found_next = self_found_reg;
        self_idx_next   = self_idx_reg;
        opp_found_next  = opp_found_reg;
        opp_idx_next    = opp_idx_reg;
        opp_id_next     = opp_id_reg;
        best_next       = best_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_opp_next    = out_opp_reg;
        out_ent_next    = out_ent_reg;
        out_last_next   = out_last_reg;
        out_lcnt_next   = out_lcnt_reg;

        if (cmd.load)
        begin
            req_func_next   = s_tuser;
            req_id_next     = in_id;
            req_rating_next = in_rating;
            list_n_next     = n_in;
            ptr_next        = '0;
            self_found_next = 1'b0;
            opp_found_next  = 1'b0;
            best_next       = (RATING_W + 1)'(rating_tolerance) + (RATING_W + 1)'(1);
        end

        if (cmd.scan_eval)
        begin
            ptr_next = ptr_inc;
            if (ent_id == req_id_reg)
            begin
                if (!self_found_reg)
                begin
                    self_found_next = 1'b1;
                    self_idx_next   = ptr_reg[IDX_W-1:0];
                end
            end
            else if (req_func_reg == FN_RANDOM)
            begin
                if (!opp_found_reg)
                begin
                    opp_found_next = 1'b1;
                    opp_idx_next   = ptr_reg[IDX_W-1:0];
                    opp_id_next    = ent_id;
                end
            end
            else if (req_func_reg == FN_RATED)
            begin
                if (tol_ok)
                begin
                    best_next      = {1'b0, diff};
                    opp_found_next = 1'b1;
                    opp_idx_next   = ptr_reg[IDX_W-1:0];
                    opp_id_next    = ent_id;
                end
            end
        end

        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        // Compaction: the write pointer starts at the first removed slot and the
        // read pointer walks on from there, skipping the removed entries.
        if (cmd.cmp_init)
        begin
            wptr_next = first_rm;
            ptr_next  = CNT_W'(first_rm) + CNT_W'(1);
        end

        if (cmd.ptr_skip)
        begin
            ptr_next = ptr_inc;
        end

        if (cmd.cmp_write)
        begin
            wptr_next = wptr_reg + IDX_W'(1);
            ptr_next  = ptr_inc;
        end

        if (cmd.cnt_sub)
        begin
            count_next = count_reg - nrem;
        end

        if (cmd.set_status)
        begin
            status_next = cmd.status;
        end

        priority if (cmd.out_result)
        begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_opp_next    = (status_reg == ST_MATCHED) ? opp_id_reg : '0;
            out_ent_next    = '0;
            out_last_next   = 1'b1;
            out_lcnt_next   = LCNT_W'(count_reg);
        end
        else if (cmd.out_entry)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ST_ENTRY;
            out_opp_next    = '0;
            out_ent_next    = ent_id;
            out_last_next   = sts.list_last;
            out_lcnt_next   = LCNT_W'(count_reg);
            ptr_next        = ptr_inc;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            self_found_reg <= 1'b0;
            opp_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            self_found_reg <= self_found_next;
            opp_found_reg  <= opp_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_func_reg   <= req_func_next;
        req_id_reg     <= req_id_next;
        req_rating_reg <= req_rating_next;
        list_n_reg     <= list_n_next;
        ptr_reg        <= ptr_next;
        wptr_reg       <= wptr_next;
        self_idx_reg   <= self_idx_next;
        opp_idx_reg    <= opp_idx_next;
        opp_id_reg     <= opp_id_next;
        best_reg       <= best_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_opp_reg    <= out_opp_next;
        out_ent_reg    <= out_ent_next;
        out_last_reg   <= out_last_next;
        out_lcnt_reg   <= out_lcnt_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_lcnt_reg, out_ent_reg, out_opp_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append did not grow the list by one");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_result || cmd.out_entry) |-> out_free)
        else $error("output register overwritten while a beat is pending");

    a_wptr_behind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmp_write |-> (CNT_W'(wptr_reg) < ptr_reg))
        else $error("compaction write pointer caught up with read pointer");

endmodule

`default_nettype wire

>>> rtl/core/ready_list_matchmaker_top.sv
// Set ready, remove and match scan the N entries, take a decision, close gaps by moving
// entries down past the removed ones, and load the result beat once the output is free.
// A list request reads and emits one id at a time; one request is worked at a time, so
// throughput is set by that scan and compaction loop over the single RAM read port.
// Reset empties the list and sets the rating tolerance to 100; entries need no clearing.
`default_nettype none

module ready_list_matchmaker_top #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // APB-style configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rlm_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [rlm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [rlm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    // Request stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: player_id [30:0], player_rating [46:31], id_limit [51:47], zero pad.
    input  wire logic [rlm_pkg::IN_TDATA_W-1:0]     s_tdata,
    // s_tuser: func [2:0].
    input  wire logic [rlm_pkg::FUNC_W-1:0]         s_tuser,
    // Result stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: opponent_id [30:0], entry_id [61:31], list_count [66:62], zero pad.
    output logic      [rlm_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // m_tuser: status [3:0].
    output logic      [rlm_pkg::STATUS_W-1:0]       m_tuser,
    output logic                                    m_tlast
);

    import rlm_pkg::*;

    logic [RATING_W-1:0] tolerance_reg;
    logic [RATING_W-1:0] tolerance_next;
    logic                cfg_wr;
    cmd_t                cmd;
    sts_t                sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[APB_ADDR_W-1] == REG_IDX_TOLERANCE);

    assign tolerance_next = cfg_wr ? pwdata[RATING_W-1:0] : tolerance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOLERANCE_RESET;
        end
        else
        begin
            tolerance_reg <= tolerance_next;
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1] == REG_IDX_TOLERANCE)
                  ? APB_DATA_W'(tolerance_reg) : '0;

    rlm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rlm_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .rating_tolerance (tolerance_reg),
        .cmd              (cmd),
        .sts              (sts),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast)
    );

endmodule

`default_nettype wire
